@@ design/bks_pkg.sv @@
// ----------------------------------------------------------------------------
// bks_pkg: shared constants and types of the ball kinematics step
// register indexes, reset values, request and result payload types
// ----------------------------------------------------------------------------
`default_nettype none
package bks_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_FORCE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MASS = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ELAST = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FRICTION = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RADIUS = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BOUND_X = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_BOUND_Y = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_STEP_TIME = 3'd7;

	localparam logic [30:0] RST_FORCE = 31'd655360000;
	localparam logic [30:0] RST_MASS = 31'd65536000;
	localparam logic [16:0] RST_ELAST = 17'd0;
	localparam logic [30:0] RST_FRICTION = 31'd3277;
	localparam logic [30:0] RST_RADIUS = 31'd1966080;
	localparam logic [14:0] RST_BOUND_X = 15'd1500;
	localparam logic [14:0] RST_BOUND_Y = 15'd900;
	localparam logic [31:0] RST_STEP_TIME = 32'd29826162;
	localparam logic signed [31:0] RST_BALL_X = 32'sd49152000;
	localparam logic signed [31:0] RST_BALL_Y = 32'sd29491200;

	localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

	typedef struct packed {
		logic key_up;
		logic key_down;
		logic key_left;
		logic key_right;
		logic friction_enable;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic friction_shown;
	} rsp_t;

	typedef struct packed {
		logic [30:0] force_cfg;
		logic [30:0] mass;
		logic [16:0] elasticity;
		logic [30:0] friction;
		logic [30:0] radius;
		logic [14:0] bound_x;
		logic [14:0] bound_y;
		logic [31:0] step_time;
	} cfg_t;
endpackage
`default_nettype wire

@@ design/bks_if.sv @@
// ----------------------------------------------------------------------------
// bks_req_if / bks_rsp_if: valid-ready channels of the ball kinematics step
// carry one request or one result item
// ----------------------------------------------------------------------------
`default_nettype none
interface bks_req_if;
	logic valid;
	logic ready;
	bks_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bks_rsp_if;
	logic valid;
	logic ready;
	bks_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/bks_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bks_cfg_regs: configuration register file
// write-only registers, masked to their widths
// ----------------------------------------------------------------------------
`default_nettype none
module bks_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [bks_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [bks_pkg::CfgDataW-1:0] cfg_wdata,
	output bks_pkg::cfg_t cfg
);
	bks_pkg::cfg_t cfg_q;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_cfg <= bks_pkg::RST_FORCE;
			cfg_q.mass <= bks_pkg::RST_MASS;
			cfg_q.elasticity <= bks_pkg::RST_ELAST;
			cfg_q.friction <= bks_pkg::RST_FRICTION;
			cfg_q.radius <= bks_pkg::RST_RADIUS;
			cfg_q.bound_x <= bks_pkg::RST_BOUND_X;
			cfg_q.bound_y <= bks_pkg::RST_BOUND_Y;
			cfg_q.step_time <= bks_pkg::RST_STEP_TIME;
		end else if (cfg_we) begin
			case (cfg_idx)
				bks_pkg::REG_FORCE: cfg_q.force_cfg <= cfg_wdata[30:0];
				bks_pkg::REG_MASS: cfg_q.mass <= cfg_wdata[30:0];
				bks_pkg::REG_ELAST: cfg_q.elasticity <= cfg_wdata[16:0];
				bks_pkg::REG_FRICTION: cfg_q.friction <= cfg_wdata[30:0];
				bks_pkg::REG_RADIUS: cfg_q.radius <= cfg_wdata[30:0];
				bks_pkg::REG_BOUND_X: cfg_q.bound_x <= cfg_wdata[14:0];
				bks_pkg::REG_BOUND_Y: cfg_q.bound_y <= cfg_wdata[14:0];
				bks_pkg::REG_STEP_TIME: cfg_q.step_time <= cfg_wdata;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/bks_seq_div.sv @@
// ----------------------------------------------------------------------------
// bks_seq_div: restoring divider, one quotient bit per cycle
// 64-bit dividend by 32-bit divisor, used for accel and rescale
// ----------------------------------------------------------------------------
`default_nettype none
module bks_seq_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] dividend,
	input wire logic [31:0] divisor,
	output logic busy,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0] cnt_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial = shifted - {1'b0, dvs_q};
	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	// remainder stays below the divisor, so it fits 32 bits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ design/bks_core.sv @@
// ----------------------------------------------------------------------------
// bks_core: step sequencer around one shared 32x32 multiplier, the divider
// and a bit-serial square root
// ----------------------------------------------------------------------------
`default_nettype none
module bks_core (
	input wire logic clk,
	input wire logic arst_n,
	input bks_pkg::cfg_t cfg,
	bks_req_if.sink req,
	bks_rsp_if.source rsp
);
	typedef enum logic [4:0] {
		S_IDLE, S_DIVW, S_DIAG, S_DVX, S_DVY, S_PXA, S_PXB, S_PYA, S_PYB,
		S_VEL, S_SQX, S_SQY, S_ROOT, S_LOSS, S_MX, S_DIVX, S_MY, S_DIVY,
		S_WL, S_WT, S_WR, S_WB, S_BNC, S_OUT
	} state_t;

	state_t st_q, ret_q;
	bks_pkg::req_t rq_q;
	logic signed [31:0] bx_q, by_q, vx_q, vy_q;
	logic signed [31:0] px_q, py_q, dvx_q, dvy_q, tmp_q;
	logic [31:0] amag_q, sp_q, ns_q;
	logic [63:0] sum_q, rem_q, res_q, bit_q;
	logic bnc_y_q;
	logic rsp_valid_q;
	bks_pkg::rsp_t rsp_q;

	// shared multiplier
	logic [31:0] ma, mb;
	logic [63:0] mp;
	assign mp = ma * mb;

	logic div_start, div_busy;
	logic [63:0] div_n, div_quo;
	logic [31:0] div_d;
	bks_seq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .busy(div_busy), .quotient(div_quo)
	);

	function automatic logic [31:0] mag(input logic signed [31:0] v);
		mag = v[31] ? 32'(-v) : v;
	endfunction

	function automatic logic signed [33:0] sat(input logic signed [33:0] v);
		if (v > 34'sd2147483647) sat = 34'sd2147483647;
		else if (v < -34'sd2147483648) sat = -34'sd2147483648;
		else sat = v;
	endfunction

	// rounded and signed product, shift sh is 16, 32 or 33
	function automatic logic signed [33:0] rnd(input logic [63:0] p, input logic neg,
			input logic [5:0] sh);
		logic [64:0] t;
		logic [33:0] r;
		t = {1'b0, p} + (65'd1 << (sh - 6'd1));
		r = 34'(t >> sh);
		rnd = neg ? -$signed(r) : $signed(r);
	endfunction

	logic signed [31:0] mul_src;
	logic [5:0] mul_sh;
	logic signed [33:0] mul_r;
	logic signed [1:0] dx, dy;
	logic [63:0] rt_tst;
	logic signed [33:0] acc;
	logic signed [31:0] rx, bxw, byw;

	assign dx = $signed({1'b0, rq_q.key_right}) - $signed({1'b0, rq_q.key_left});
	assign dy = $signed({1'b0, rq_q.key_down}) - $signed({1'b0, rq_q.key_up});
	assign rt_tst = res_q + bit_q;
	assign rx = $signed({1'b0, cfg.radius});
	assign bxw = $signed({1'b0, cfg.bound_x, 16'd0});
	assign byw = $signed({1'b0, cfg.bound_y, 16'd0});

	always_comb begin
		mul_src = '0;
		mul_sh = 6'd32;
		ma = '0;
		mb = cfg.step_time;
		case (st_q)
			S_DIAG: begin ma = amag_q; mb = bks_pkg::INV_SQRT2_Q32; end
			S_DVX: mul_src = (dx == 2'sd0) ? 32'sd0 : (dx > 2'sd0 ? amag_q : -amag_q);
			S_DVY: mul_src = (dy == 2'sd0) ? 32'sd0 : (dy > 2'sd0 ? amag_q : -amag_q);
			S_PXA: begin mul_src = dvx_q; mul_sh = 6'd33; end
			S_PXB: mul_src = vx_q;
			S_PYA: begin mul_src = dvy_q; mul_sh = 6'd33; end
			S_PYB: mul_src = vy_q;
			S_SQX: begin ma = mag(px_q); mb = mag(px_q); end
			S_SQY: begin ma = mag(py_q); mb = mag(py_q); end
			S_LOSS: ma = {1'b0, cfg.friction};
			S_MX: begin ma = mag(tmp_q); mb = ns_q; end
			S_MY: begin ma = mag(dvy_q); mb = ns_q; end
			S_BNC: begin
				mul_src = bnc_y_q ? vy_q : vx_q;
				mb = {15'd0, cfg.elasticity};
				mul_sh = 6'd16;
			end
			default: ;
		endcase
		if (st_q == S_DVX || st_q == S_DVY || st_q == S_PXA || st_q == S_PXB
				|| st_q == S_PYA || st_q == S_PYB || st_q == S_BNC)
			ma = mag(mul_src);
		mul_r = rnd(mp, mul_src[31], mul_sh);
		acc = '0;
		div_start = 1'b0;
		div_n = {17'd0, cfg.force_cfg, 16'd0};
		div_d = {1'b0, cfg.mass};
		case (st_q)
			S_IDLE: div_start = req.valid;
			S_MX: begin
				div_start = 1'b1;
				div_n = mp + {33'd0, sp_q[31:1]};
				div_d = sp_q;
			end
			S_MY: begin
				div_start = 1'b1;
				div_n = mp + {33'd0, sp_q[31:1]};
				div_d = sp_q;
			end
			default: ;
		endcase
		if (st_q == S_PXB) acc = sat(34'(px_q) + 34'(tmp_q) + mul_r);
		else acc = sat(34'(py_q) + 34'(tmp_q) + mul_r);
	end

	assign req.ready = (st_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			bx_q <= bks_pkg::RST_BALL_X;
			by_q <= bks_pkg::RST_BALL_Y;
			vx_q <= '0;
			vy_q <= '0;
			bnc_y_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (req.valid && !rsp_valid_q) begin
					rq_q <= req.data;
					st_q <= S_DIVW;
				end
				S_DIVW: if (!div_busy) begin
					amag_q <= (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
					st_q <= S_DIAG;
				end
				S_DIAG: begin
					if (dx != 2'sd0 && dy != 2'sd0)
						amag_q <= 32'((mp + 64'h8000_0000) >> 32);
					st_q <= S_DVX;
				end
				S_DVX: begin dvx_q <= 32'(mul_r); st_q <= S_DVY; end
				S_DVY: begin dvy_q <= 32'(mul_r); st_q <= S_PXA; end
				S_PXA: begin tmp_q <= 32'(mul_r); px_q <= bx_q; st_q <= S_PXB; end
				S_PXB: begin px_q <= 32'(acc); st_q <= S_PYA; end
				S_PYA: begin tmp_q <= 32'(mul_r); py_q <= by_q; st_q <= S_PYB; end
				S_PYB: begin
					py_q <= 32'(acc);
					tmp_q <= px_q;
					st_q <= S_VEL;
				end
				S_VEL: begin
					// keep positions in bx/by scratch, velocities in px/py
					bx_q <= tmp_q;
					by_q <= py_q;
					px_q <= 32'(sat(34'(vx_q) + 34'(dvx_q)));
					py_q <= 32'(sat(34'(vy_q) + 34'(dvy_q)));
					st_q <= S_SQX;
				end
				S_SQX: begin sum_q <= mp; st_q <= S_SQY; end
				S_SQY: begin
					rem_q <= sum_q + mp;
					res_q <= '0;
					bit_q <= 64'd1 << 62;
					st_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rem_q >= rt_tst) begin
						rem_q <= rem_q - rt_tst;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 64'd1) st_q <= S_LOSS;
				end
				S_LOSS: begin
					sp_q <= res_q[31:0];
					vx_q <= px_q;
					vy_q <= py_q;
					tmp_q <= px_q;
					dvy_q <= py_q;
					if (res_q[31:0] == 32'd0) begin
						vx_q <= '0;
						vy_q <= '0;
						st_q <= S_WL;
					end else if (rq_q.friction_enable) begin
						ns_q <= (res_q[31:0] > 32'((mp + 64'h8000_0000) >> 32))
							? res_q[31:0] - 32'((mp + 64'h8000_0000) >> 32) : 32'd0;
						st_q <= S_MX;
					end else begin
						st_q <= S_WL;
					end
				end
				S_MX: st_q <= S_DIVX;
				S_DIVX: if (!div_busy) begin
					vx_q <= tmp_q[31] ? -$signed(div_quo[31:0]) : div_quo[31:0];
					st_q <= S_MY;
				end
				S_MY: st_q <= S_DIVY;
				S_DIVY: if (!div_busy) begin
					vy_q <= dvy_q[31] ? -$signed(div_quo[31:0]) : div_quo[31:0];
					if (ns_q == 32'd0) begin
						vx_q <= '0;
						vy_q <= '0;
					end
					st_q <= S_WL;
				end
				S_WL: begin
					if (bx_q < rx) begin
						bx_q <= rx; bnc_y_q <= 1'b0; ret_q <= S_WT; st_q <= S_BNC;
					end else st_q <= S_WT;
				end
				S_WT: begin
					if (by_q < rx) begin
						by_q <= rx; bnc_y_q <= 1'b1; ret_q <= S_WR; st_q <= S_BNC;
					end else st_q <= S_WR;
				end
				S_WR: begin
					if (34'(bx_q) + 34'(rx) > 34'(bxw)) begin
						bx_q <= bxw - rx; bnc_y_q <= 1'b0; ret_q <= S_WB; st_q <= S_BNC;
					end else st_q <= S_WB;
				end
				S_WB: begin
					if (34'(by_q) + 34'(rx) > 34'(byw)) begin
						by_q <= byw - rx; bnc_y_q <= 1'b1; ret_q <= S_OUT; st_q <= S_BNC;
					end else st_q <= S_OUT;
				end
				S_BNC: begin
					if (bnc_y_q) vy_q <= 32'(sat(-mul_r));
					else vx_q <= 32'(sat(-mul_r));
					st_q <= ret_q;
				end
				S_OUT: begin
					rsp_q.pos_x <= bx_q;
					rsp_q.pos_y <= by_q;
					rsp_q.vel_x <= vx_q;
					rsp_q.vel_y <= vy_q;
					rsp_q.friction_shown <= rq_q.friction_enable;
					rsp_valid_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/ball_kinematics_step.sv @@
// ----------------------------------------------------------------------------
// ball_kinematics_step: one fixed time step of a ball with friction and bounce
// Q16.16 kinematics with saturation, wall snap and restitution
// ----------------------------------------------------------------------------
// One step runs from the accepted request to a valid result through a
// bit-serial divide of the acceleration, a bit-serial square root for the
// speed, a check per wall and a bounce per wall hit and, with friction on
// and a nonzero speed, two more divides plus their setup for the rescale,
// all around one shared 32x32 multiplier. The block takes no new request
// until the result of the previous one has been delivered.
`default_nettype none
module ball_kinematics_step (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [bks_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [bks_pkg::CfgDataW-1:0] cfg_wdata,
	bks_req_if.sink req,
	bks_rsp_if.source rsp
);
	bks_pkg::cfg_t cfg;

	bks_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .cfg(cfg)
	);

	bks_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp)
	);
endmodule
`default_nettype wire
